### rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none
package dtq_pkg;

	localparam int TIME_W      = 48;
	localparam int DELAY_W     = 20;
	localparam int ID_W        = 16;
	localparam int MAX_RESULTS = 16;
	localparam int N_W         = $clog2(MAX_RESULTS);

	// Operation codes of an input word.
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_ADD   = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	// Status codes of a result word.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [DELAY_W-1:0] delay;
		logic [ID_W-1:0]    task_id;
	} in_word_t;

	typedef struct packed {
		logic [1:0]      status;
		logic            new_earliest;
		logic            task_valid;
		logic [ID_W-1:0] expired_task;
		logic            is_last;
	} out_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input word
		logic exec;      // run start, stop or add and emit its result
		logic advance;   // advance time by one tick
		logic emit_pop;  // emit the head task and remove it
		logic emit_idle; // emit the empty tick result
		logic last;      // last flag for emit_pop
	} dtq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic out_free;
		logic due0;
		logic due1;
	} dtq_sts_t;

endpackage
`default_nettype wire

### rtl/dtq_chan_if.sv
// ----------------------------------------------------------------------------
// dtq_chan_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
`default_nettype none
interface dtq_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/deadline_timer_queue_top.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_top
// Deadline-ordered timer queue with start, stop, add and tick words.
// ----------------------------------------------------------------------------
// Start, stop and add: captured in the idle state, result registered from the
// execute state once the output is free; the next word waits for idle again.
// Tick: time advances in the execute state, then the drain state registers
// one dispatched task per cycle from the head cell while the output is free;
// the next word is taken once the controller is back in idle.
// Asynchronous reset stops the queue, clears time and count; cells unreset.
`default_nettype none
module deadline_timer_queue_top #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int TASK_ID_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	dtq_chan_if.sink   in_ch,
	dtq_chan_if.source out_ch
);
	import dtq_pkg::*;

	dtq_cmd_t cmd;
	dtq_sts_t sts;

	dtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dtq_dpath #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.TASK_ID_BITS (TASK_ID_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_ch.data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_ch.data)
	);
endmodule
`default_nettype wire

### rtl/dtq_ctrl.sv
// ----------------------------------------------------------------------------
// dtq_ctrl
// Controller: sequences one word at a time and the tick dispatch loop.
// ----------------------------------------------------------------------------
`default_nettype none
module dtq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire dtq_pkg::dtq_sts_t sts,
	output dtq_pkg::dtq_cmd_t      cmd
);
	import dtq_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DRAIN} state_t;

	state_t         state_q;
	logic [N_W-1:0] n_q;
	logic           last_pop;

	assign in_ready = (state_q == S_IDLE);
	assign last_pop = !sts.due1 || (n_q == N_W'(MAX_RESULTS - 1));

	// Command decode.
	always_comb begin
		cmd = '0;
		cmd.last = last_pop;
		unique case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_EXEC: begin
				if (sts.op == OP_TICK) cmd.advance = 1'b1;
				else cmd.exec = sts.out_free;
			end
			S_DRAIN: begin
				if (sts.out_free) begin
					if (sts.due0) cmd.emit_pop = 1'b1;
					else cmd.emit_idle = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

	// State and dispatch count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: begin
					if (sts.op == OP_TICK) begin
						n_q     <= '0;
						state_q <= S_DRAIN;
					end else if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DRAIN: begin
					if (sts.out_free) begin
						if (sts.due0 && !last_pop) n_q <= n_q + N_W'(1);
						else state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/dtq_dpath.sv
// ----------------------------------------------------------------------------
// dtq_dpath
// Datapath: run state, time, sorted row of entry cells and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module dtq_dpath #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int TASK_ID_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dtq_pkg::in_word_t in_data,
	input  wire dtq_pkg::dtq_cmd_t cmd,
	output dtq_pkg::dtq_sts_t      sts,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output dtq_pkg::out_word_t     out_data
);
	import dtq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// Captured input word.
	op_t                 op_q;
	logic [DELAY_W-1:0]  delay_q;
	logic [TASK_ID_BITS-1:0] id_q;

	logic                running_q;
	logic [TIME_W-1:0]   time_q;
	logic [CW-1:0]       count_q;
	logic                out_valid_q;
	out_word_t           out_q;
	out_word_t           res_d;

	logic [TIME_W-1:0]       dl_q [QUEUE_DEPTH];
	logic [TASK_ID_BITS-1:0] tk_q [QUEUE_DEPTH];

	logic [TIME_W-1:0]    new_dl;
	logic [QUEUE_DEPTH-1:0] le;
	logic                 full;
	logic                 do_insert;

	assign new_dl    = time_q + TIME_W'(delay_q);
	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign do_insert = cmd.exec && (op_q == OP_ADD) && running_q && !full;

	// Per cell: stored entry is valid and not later than the new deadline.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			le[i] = (CW'(i) < count_q) && (dl_q[i] <= new_dl);
		end
	end

	assign sts.op       = op_q;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.due0     = running_q && (count_q != '0) && (dl_q[0] <= time_q);
	assign sts.due1     = running_q && (count_q > CW'(1)) && (dl_q[1] <= time_q);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Input word capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(in_data.opcode);
			delay_q <= in_data.delay;
			id_q    <= TASK_ID_BITS'(in_data.task_id);
		end
	end

	// Entry cells: sorted insert or shift toward the head.
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_insert) begin
				if (!le[g]) begin
					if (g == 0 || le[(g == 0) ? 0 : g - 1]) begin
						dl_q[g] <= new_dl;
						tk_q[g] <= id_q;
					end else begin
						dl_q[g] <= dl_q[(g == 0) ? 0 : g - 1];
						tk_q[g] <= tk_q[(g == 0) ? 0 : g - 1];
					end
				end
			end else if (cmd.emit_pop && g < QUEUE_DEPTH - 1) begin
				dl_q[g] <= dl_q[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
				tk_q[g] <= tk_q[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
			end
		end
	end

	// Control state: run flag, time, fill count, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			time_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec || cmd.emit_pop || cmd.emit_idle) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cmd.advance) time_q <= time_q + TIME_W'(1);
			if (cmd.emit_pop) count_q <= count_q - CW'(1);
			if (cmd.exec) begin
				case (op_q)
					OP_START: running_q <= 1'b1;
					OP_STOP: begin
						running_q <= 1'b0;
						count_q   <= '0;
					end
					OP_ADD: if (do_insert) count_q <= count_q + CW'(1);
					default: ;
				endcase
			end
		end
	end

	// Next result word; the empty tick result is the all-zero last word.
	always_comb begin
		res_d = '0;
		res_d.is_last = 1'b1;
		if (cmd.exec) begin
			case (op_q)
				OP_START: res_d.status = running_q ? ST_REFUSED : ST_OK;
				OP_STOP:  res_d.status = running_q ? ST_OK : ST_REFUSED;
				OP_ADD: begin
					if (!running_q) res_d.status = ST_REFUSED;
					else if (full) res_d.status = ST_FULL;
					else begin
						res_d.status       = ST_OK;
						res_d.new_earliest = !le[0];
					end
				end
				default: res_d.status = ST_OK;
			endcase
		end else if (cmd.emit_pop) begin
			res_d.task_valid   = 1'b1;
			res_d.expired_task = ID_W'(tk_q[0]);
			res_d.is_last      = cmd.last;
		end
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (cmd.exec || cmd.emit_pop || cmd.emit_idle) out_q <= res_d;
	end
endmodule
`default_nettype wire

### rtl/dtq_checker.sv
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module dtq_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire dtq_pkg::out_word_t out_data
);
	import dtq_pkg::*;

	// A stalled result word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// One word is worked at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in work");

	// A dispatched task is always an accepted tick result.
	a_task_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.task_valid |-> out_data.status == ST_OK
			&& !out_data.new_earliest)
		else $error("dispatch with bad status");

	// No task id without a dispatch.
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.task_valid |-> out_data.expired_task == '0
			&& out_data.is_last)
		else $error("stray task id or missing last mark");
endmodule

bind deadline_timer_queue_top dtq_checker u_dtq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
`default_nettype wire

### bench/deadline_timer_queue_top_tb.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_top_tb
// Checks the deadline timer queue against a behavioral model of its queue.
// ----------------------------------------------------------------------------
// Directed tests cover refused starts, stops and adds, a full store, equal
// deadlines, a tick that dispatches the whole store and maximum delay. Random
// tests then run sessions of adds and ticks with random gaps on both sides.
`default_nettype none
module deadline_timer_queue_top_tb;
	import dtq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = 16;
	localparam int WDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dtq_chan_if #(.T(in_word_t))  in_ch ();
	dtq_chan_if #(.T(out_word_t)) out_ch ();

	deadline_timer_queue_top #(.QUEUE_DEPTH(DEPTH), .TASK_ID_BITS(ID_W)) DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #1 clk = ~clk;

	// Model state of the queue.
	logic                q_running;
	logic [TIME_W-1:0]   q_now;
	logic [TIME_W-1:0]   q_deadline[DEPTH];
	logic [ID_W-1:0]     q_task[DEPTH];
	int                  q_count;

	out_word_t expected_words[$];
	int        mismatches;
	int        idle_cycles;
	int        out_stall = 0;
	logic      timed_out;

	// Work out the result words of one input word and update the model.
	task automatic predict_word(input in_word_t w);
		out_word_t r;
		int pos;
		int n;
		r = '0;
		r.is_last = 1'b1;
		case (op_t'(w.opcode))
			OP_START: begin
				if (q_running) r.status = ST_REFUSED;
				else q_running = 1'b1;
				expected_words.push_back(r);
			end
			OP_STOP: begin
				if (!q_running) r.status = ST_REFUSED;
				else begin
					q_running = 1'b0;
					q_count = 0;
				end
				expected_words.push_back(r);
			end
			OP_ADD: begin
				if (!q_running) r.status = ST_REFUSED;
				else if (q_count >= DEPTH) r.status = ST_FULL;
				else begin
					pos = 0;
					while (pos < q_count && q_deadline[pos] <= q_now + TIME_W'(w.delay))
						pos++;
					for (int i = q_count; i > pos; i--) begin
						q_deadline[i] = q_deadline[i-1];
						q_task[i] = q_task[i-1];
					end
					q_deadline[pos] = q_now + TIME_W'(w.delay);
					q_task[pos] = w.task_id;
					q_count++;
					r.new_earliest = (pos == 0);
				end
				expected_words.push_back(r);
			end
			default: begin
				q_now = q_now + 1'b1;
				n = 0;
				while (q_running && q_count > 0 && n < MAX_RESULTS && q_deadline[0] <= q_now) begin
					r = '0;
					r.task_valid = 1'b1;
					r.expired_task = q_task[0];
					expected_words.push_back(r);
					for (int i = 1; i < q_count; i++) begin
						q_deadline[i-1] = q_deadline[i];
						q_task[i-1] = q_task[i];
					end
					q_count--;
					n++;
				end
				if (n == 0) expected_words.push_back(r);
				else expected_words[$].is_last = 1'b1;
			end
		endcase
	endtask

	// Random gap length: mostly none or short, now and then long.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Send one word and predict its results on acceptance. Valid stays high
	// after acceptance so that a following word without a gap is driven once.
	task automatic send_word(input op_t op, input logic [DELAY_W-1:0] dl,
			input logic [ID_W-1:0] id);
		in_word_t w;
		int g;
		w.opcode = op;
		w.delay = dl;
		w.task_id = id;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_word(w);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_word(OP_TICK, DELAY_W'($urandom), ID_W'($urandom));
	endtask

	task automatic drain();
		while (expected_words.size() != 0 && !timed_out) @(posedge clk);
	endtask

	// Refused words in both running states and a start-stop cycle.
	task automatic test_state_rules();
		send_word(OP_STOP, '0, '0);
		send_word(OP_ADD, 20'd5, 16'h1234);
		send_ticks(1);
		send_word(OP_START, '0, '0);
		send_word(OP_START, '1, '1);
		send_word(OP_ADD, 20'd3, 16'hFFFF);
		send_word(OP_STOP, '0, '0);
		send_ticks(4);
	endtask

	// Fill the store, overflow it, and dispatch it all on one tick.
	task automatic test_full_store();
		send_word(OP_START, '0, '0);
		for (int i = 0; i < DEPTH; i++)
			send_word(OP_ADD, (i % 3 == 0) ? 20'd1 : 20'd0, ID_W'(i + 16'hA000));
		send_word(OP_ADD, 20'd0, 16'h0000);
		send_ticks(2);
	endtask

	// Equal deadlines keep insertion order; maximum delay.
	task automatic test_ordering();
		send_word(OP_ADD, 20'd2, 16'h0001);
		send_word(OP_ADD, 20'd2, 16'h0002);
		send_word(OP_ADD, 20'd1, 16'h5555);
		send_word(OP_ADD, '1, 16'hAAAA);
		send_ticks(3);
		send_word(OP_STOP, '0, '0);
	endtask

	// Sessions of adds and ticks with random content, some noise words.
	task automatic test_random(input int words);
		int sent;
		int p;
		sent = 0;
		send_word(OP_START, '0, '0);
		while (sent < words) begin
			p = $urandom_range(0, 99);
			if (p < 45)
				send_word(OP_ADD, ($urandom_range(0, 9) == 0) ? DELAY_W'($urandom)
					: DELAY_W'($urandom_range(0, 12)), ID_W'($urandom));
			else if (p < 94) send_ticks(1);
			else if (p < 97) send_word(OP_STOP, DELAY_W'($urandom), ID_W'($urandom));
			else send_word(OP_START, DELAY_W'($urandom), ID_W'($urandom));
			sent++;
		end
	endtask

	// Result checker with random receiver stalls, mostly short, a few long.
	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %p", out_ch.data);
				end else begin
					e = expected_words.pop_front();
					if (out_ch.data !== e) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", e, out_ch.data);
					end
				end
			end
			if (out_stall > 0) begin
				out_ch.ready <= 1'b0;
				out_stall <= out_stall - 1;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 99) < 30) out_stall <= gap_len();
			end
		end
	end

	// Watchdog on cycles with no accepted word on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				timed_out = 1'b1;
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		q_running = 1'b0;
		q_now = '0;
		q_count = 0;
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_state_rules();
		test_full_store();
		test_ordering();
		test_random(390);
		in_ch.valid <= 1'b0;
		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
